// ===== hdl/bavg_pkg.sv =====
// Shared widths, constants and types of the block average decimator.
package bavg_pkg;

  // Field widths.
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int COUNT_BITS    = 8;
  localparam int AVG_BITS      = 24;

  // The count never exceeds 255, so the group sum fits in this width.
  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  // The dividend is the sum magnitude with the fraction bits appended.
  localparam int DIVD_BITS = SUM_BITS + FRACTION_BITS;
  // Width used to compare the quotient against the result range.
  localparam int CMP_BITS  = (DIVD_BITS > AVG_BITS) ? DIVD_BITS : AVG_BITS + 1;
  localparam int STEP_BITS = $clog2(DIVD_BITS);

  // Queue between the accumulator and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Reset value of the group size register.
  localparam logic [COUNT_BITS-1:0] GROUP_SIZE_RESET = COUNT_BITS'(4);

  // Result range limits.
  localparam logic [AVG_BITS-1:0] AVG_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
  localparam logic [AVG_BITS-1:0] AVG_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};
  localparam logic [CMP_BITS-1:0] AVG_MAX_MAG = CMP_BITS'(AVG_MAX);
  localparam logic [CMP_BITS-1:0] AVG_MIN_MAG = CMP_BITS'(AVG_MIN);

  // One closed group, handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]      count;
    logic                       partial;
  } job_t;

endpackage

// ===== hdl/bavg_front.sv =====
// Accumulator: sums samples, counts them and closes groups into jobs.
module bavg_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [bavg_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 in_last,
  input  logic [bavg_pkg::COUNT_BITS-1:0]      group_size,
  output logic                                 q_push,
  input  logic                                 q_full,
  output bavg_pkg::job_t                       q_job
);

  logic signed [bavg_pkg::SUM_BITS-1:0] sum_r, sum_nxt;
  logic [bavg_pkg::COUNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic signed [bavg_pkg::SUM_BITS-1:0] sum_add;
  logic [bavg_pkg::COUNT_BITS-1:0]      cnt_add;
  logic                                 accept;
  logic                                 group_full;
  logic                                 close;

  // Hold off the source whenever the job queue has no room.
  assign in_full = q_full;
  assign accept  = in_push && !in_full;

  // Running sum and count including the incoming sample.
  assign sum_add    = sum_r + {{bavg_pkg::COUNT_BITS{in_sample[bavg_pkg::SAMPLE_BITS-1]}},
                               in_sample};
  assign cnt_add    = cnt_r + bavg_pkg::COUNT_BITS'(1);
  assign group_full = (cnt_add >= group_size);
  assign close      = accept && (group_size != '0) && (group_full || in_last);

  // Closed group goes to the divider.
  assign q_push        = close;
  assign q_job.sum     = sum_add;
  assign q_job.count   = cnt_add;
  assign q_job.partial = !group_full;

  // Next accumulator state.
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (group_size == '0 || close) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // A sample taken while grouping is off leaves a cleared accumulator.
  a_zero_size_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && group_size == '0) |=> (cnt_r == '0 && sum_r == '0))
    else $error("accumulator not cleared with group size zero");

  // Jobs are only pushed into a queue with room.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // A job always carries a nonzero divisor.
  a_job_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_job.count != '0))
    else $error("job pushed with zero sample count");
`endif

endmodule

// ===== hdl/bavg_queue.sv =====
// Two-entry queue of closed groups between the accumulator and the divider.
module bavg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  bavg_pkg::job_t push_job,
  input  logic           pop,
  output logic           empty,
  output bavg_pkg::job_t pop_job
);

  bavg_pkg::job_t                  mem_r [bavg_pkg::QUEUE_DEPTH];
  logic [bavg_pkg::QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [bavg_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == bavg_pkg::QCNT_BITS'(bavg_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // Occupancy update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + bavg_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - bavg_pkg::QCNT_BITS'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + bavg_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bavg_pkg::QPTR_BITS'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/bavg_back.sv =====
// Divider: turns each closed group into a fixed-point mean in the result register.
module bavg_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  bavg_pkg::job_t                       q_job,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [bavg_pkg::AVG_BITS-1:0] out_average,
  output logic                                 out_partial_group,
  output logic [bavg_pkg::COUNT_BITS-1:0]      out_samples_averaged
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } div_state_t;

  div_state_t                          state_r, state_nxt;
  logic [bavg_pkg::DIVD_BITS-1:0]      dvd_r;
  logic [bavg_pkg::COUNT_BITS:0]       rem_r;
  logic [bavg_pkg::COUNT_BITS-1:0]     div_r;
  logic [bavg_pkg::STEP_BITS-1:0]      step_r;
  logic                                neg_r;
  logic                                partial_r;
  logic                                out_valid_r;
  logic signed [bavg_pkg::AVG_BITS-1:0] avg_r;
  logic                                out_partial_r;
  logic [bavg_pkg::COUNT_BITS-1:0]     out_n_r;

  logic [bavg_pkg::SUM_BITS-1:0]       mag;
  logic [bavg_pkg::COUNT_BITS:0]       trial;
  logic                                ge;
  logic [bavg_pkg::CMP_BITS-1:0]       q_ext;
  logic [bavg_pkg::AVG_BITS-1:0]       avg_sat;
  logic                                out_free;
  logic                                out_load;

  assign out_empty            = !out_valid_r;
  assign out_average          = avg_r;
  assign out_partial_group    = out_partial_r;
  assign out_samples_averaged = out_n_r;

  // Sum magnitude of the job being taken.
  assign mag = q_job.sum[bavg_pkg::SUM_BITS-1] ?
               bavg_pkg::SUM_BITS'(-q_job.sum) : bavg_pkg::SUM_BITS'(q_job.sum);

  // One restoring division step.
  assign trial = {rem_r[bavg_pkg::COUNT_BITS-1:0], dvd_r[bavg_pkg::DIVD_BITS-1]};
  assign ge    = (trial >= {1'b0, div_r});

  // Sign and saturation of the finished quotient.
  assign q_ext = bavg_pkg::CMP_BITS'(dvd_r);
  always_comb begin
    if (neg_r) begin
      avg_sat = (q_ext > bavg_pkg::AVG_MIN_MAG) ? bavg_pkg::AVG_MIN :
                bavg_pkg::AVG_BITS'(bavg_pkg::CMP_BITS'(0) - q_ext);
    end else begin
      avg_sat = (q_ext > bavg_pkg::AVG_MAX_MAG) ? bavg_pkg::AVG_MAX :
                bavg_pkg::AVG_BITS'(q_ext);
    end
  end

  // The result register takes a new mean when it is empty or being drained.
  assign out_free = !out_valid_r || out_pop;
  assign out_load = (state_r == ST_DONE) && out_free;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd_r     <= bavg_pkg::DIVD_BITS'(mag) << bavg_pkg::FRACTION_BITS;
      rem_r     <= '0;
      div_r     <= q_job.count;
      neg_r     <= q_job.sum[bavg_pkg::SUM_BITS-1];
      partial_r <= q_job.partial;
      step_r    <= bavg_pkg::STEP_BITS'(bavg_pkg::DIVD_BITS - 1);
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge ? (trial - {1'b0, div_r}) : trial;
      dvd_r  <= {dvd_r[bavg_pkg::DIVD_BITS-2:0], ge};
      step_r <= step_r - bavg_pkg::STEP_BITS'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_r         <= avg_sat;
      out_partial_r <= partial_r;
      out_n_r       <= div_r;
    end
  end

`ifndef SYNTHESIS
  // The divisor of a running division is never zero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r != '0))
    else $error("division running with zero divisor");

  // The partial remainder stays below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {1'b0, div_r}))
    else $error("remainder not below divisor");

  // A finished mean is only written over a result that is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(avg_r)))
    else $error("waiting result overwritten");
`endif

endmodule

// ===== hdl/block_average_decimator.sv =====
// Top level of the block average decimator: accumulator, job queue and divider.
//
// Samples are taken one per clock cycle while in_full is low: the accumulator
// adds each sample in the cycle it is pushed. When a group closes (the count
// reaches group_size, or last ends a shorter non-empty group), the sum and count
// go into a two-entry job queue. A shared restoring divider works out
// sum * 256 / count, truncated toward zero, one quotient bit per cycle; it takes
// a group from the queue only when idle, so each group occupies it from the load
// through one divide step per dividend bit to the write of the result register.
// Groups no shorter than that span therefore stream at one sample per cycle
// while results are drained; with shorter groups the queue fills and in_full
// throttles the input to the divider's pace. group_size resets to 4 and zero
// drops all samples without output; write it only while the block is idle.
module block_average_decimator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [bavg_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 in_last,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [bavg_pkg::AVG_BITS-1:0] out_average,
  output logic                                 out_partial_group,
  output logic [bavg_pkg::COUNT_BITS-1:0]      out_samples_averaged,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bavg_pkg::COUNT_BITS-1:0]      cfg_group_size
);

  logic [bavg_pkg::COUNT_BITS-1:0] group_size_r;
  logic                            q_push, q_full, q_pop, q_empty;
  bavg_pkg::job_t                  push_job, pop_job;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= bavg_pkg::GROUP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      group_size_r <= cfg_group_size;
    end
  end

  bavg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .group_size (group_size_r),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_job      (push_job)
  );

  bavg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .full     (q_full),
    .push_job (push_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  bavg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .q_job                (pop_job),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_average          (out_average),
    .out_partial_group    (out_partial_group),
    .out_samples_averaged (out_samples_averaged)
  );

endmodule
